// File: rtl/core/vsu_pkg.sv
// Shared types, constants and saturation helpers for the viscoplastic stress update.
// Used by viscoplastic_stress_update; no dependencies.
package vsu_pkg;

  // Default sizing
  localparam int POINTS_DEF    = 4096;
  localparam int FRAC_BITS_DEF = 16;

  // Field widths
  localparam int IDX_W   = 12;
  localparam int IN_W    = 232;
  localparam int OUT_W   = 96;
  localparam int USER_W  = 2;
  localparam int CFG_W   = 31;

  localparam logic [30:0] MAX31 = 31'h7fff_ffff;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TIME_STEP = 1'b0,
    REG_INV_VISC  = 1'b1
  } cfg_reg_t;

  // Per-point stored state, one memory word
  typedef struct packed {
    logic signed [31:0] sxx;
    logic signed [31:0] syy;
    logic signed [31:0] sxy;
    logic        [31:0] axx;
    logic        [31:0] ayy;
    logic        [31:0] axy;
    logic        [31:0] pxx;
    logic        [31:0] pyy;
    logic        [31:0] pxy;
    logic               act;
  } pt_state_t;

  // Clamp a wide signed value to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamp an unsigned value to 31 bits
  function automatic logic [30:0] sat31u(input logic [63:0] v);
    logic [30:0] r;
    if (v > 64'(MAX31)) begin
      r = MAX31;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  // Add a nonnegative increment to an accumulator, clamp at 2^31-1
  function automatic logic [31:0] acc_sat(input logic [31:0] a, input logic [63:0] inc);
    logic [64:0] s;
    logic [31:0] r;
    s = 65'(a) + 65'(inc);
    if (s > 65'(MAX31)) begin
      r = {1'b0, MAX31};
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/vsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/viscoplastic_stress_update.sv
// Channel   Dir  Width  Contents
// s_axis    in   232    point index, strain xx/yy/xy, K, G, yield, threshold
// m_axis    out  96+2   stress xx/yy/xy; tuser plastic_active, material_redraw
// cfg       in   31     time_step (index 0), inv_viscosity (index 1)
//
// One item per cycle while tready is high; each item passes stages 1 to 7 and the output register.
// An item whose point is still in the 7-stage pipeline waits until that
// point is written back (the per-point memory read-modify-write loop).
// After reset every point memory word is cleared, with tready low.
// A stall at the output freezes every stage; the output register holds.
// Depends on vsu_pkg and vsu_ram.
module viscoplastic_stress_update #(
  parameter int POINTS    = vsu_pkg::POINTS_DEF,
  parameter int FRAC_BITS = vsu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_index, strain_xx, strain_yy, strain_xy, bulk_modulus,
  // shear_modulus, yield_stress, strain_threshold
  input  logic [vsu_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // stress_xx, stress_yy, stress_xy
  output logic [vsu_pkg::OUT_W-1:0]     m_axis_tdata,
  // plastic_active, material_redraw
  output logic [vsu_pkg::USER_W-1:0]    m_axis_tuser,
  input  logic                          cfg_wen,
  input  logic                          cfg_addr,
  input  logic [vsu_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int RSH = 24;
  localparam longint RECIP = (longint'(1) << RSH) / POINTS + 1;
  localparam logic signed [32:0] P_S = 33'(POINTS);
  localparam logic [30:0] ONE_Q = 31'(64'd1 << FRAC_BITS);
  localparam int ST_W = $bits(vsu_pkg::pt_state_t);

  // ---------------------------------------------------------------
  // Configuration registers
  logic [30:0] time_step;
  logic [30:0] inv_visc;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= ONE_Q;
      inv_visc  <= ONE_Q;
    end else if (cfg_wen) begin
      unique case (vsu_pkg::cfg_reg_t'(cfg_addr))
        vsu_pkg::REG_TIME_STEP: time_step <= cfg_wdata;
        vsu_pkg::REG_INV_VISC:  inv_visc  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input unpack and index reduction modulo POINTS
  logic [11:0]        in_idx;
  logic [39:0]        idx_prod;
  logic [15:0]        idx_q;
  logic [31:0]        idx_qp;
  logic signed [32:0] idx_rem0;
  logic signed [32:0] idx_rem;
  logic [AW-1:0]      in_pt;

  assign in_idx   = s_axis_tdata[11:0];
  assign idx_prod = 40'(in_idx) * 40'(RECIP);
  assign idx_q    = idx_prod[39:24];
  assign idx_qp   = 32'(idx_q) * 32'(POINTS);
  assign idx_rem0 = $signed({21'd0, in_idx}) - $signed({1'b0, idx_qp});

  always_comb begin
    if (idx_rem0 < 0) begin
      idx_rem = idx_rem0 + P_S;
    end else if (idx_rem0 >= P_S) begin
      idx_rem = idx_rem0 - P_S;
    end else begin
      idx_rem = idx_rem0;
    end
  end

  assign in_pt = idx_rem[AW-1:0];

  // ---------------------------------------------------------------
  // Pipeline control
  logic          adv;
  logic          accept;
  logic          hazard;
  logic          clr_busy;
  logic [AW-1:0] clr_addr;
  logic [7:1]    vld;
  logic [AW-1:0] pt [7:1];

  assign adv = !m_axis_tvalid || m_axis_tready;

  // Hold off a point that is still in flight
  always_comb begin
    hazard = 1'b0;
    for (int s = 1; s <= 7; s++) begin
      if (vld[s] && pt[s] == in_pt) begin
        hazard = 1'b1;
      end
    end
  end

  assign s_axis_tready = adv && !clr_busy && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Advance valid bits and point indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      vld           <= {vld[6:1], accept};
      m_axis_tvalid <= vld[7];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt[1] <= in_pt;
      for (int s = 2; s <= 7; s++) begin
        pt[s] <= pt[s-1];
      end
    end
  end

  // Clear the point memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(POINTS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Point memory: all per-point stores in one word
  vsu_pkg::pt_state_t st_rd;
  vsu_pkg::pt_state_t st_wr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ST_W-1:0]    mem_wdata;
  logic [ST_W-1:0]    mem_rdata;

  assign mem_we    = clr_busy || (adv && vld[7]);
  assign mem_waddr = clr_busy ? clr_addr : pt[7];
  assign mem_wdata = clr_busy ? '0 : st_wr;
  assign st_rd     = vsu_pkg::pt_state_t'(mem_rdata);

  vsu_ram #(
    .WIDTH (ST_W),
    .DEPTH (POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_pt),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------
  // Stage 1: capture input fields
  logic signed [31:0] s1_exx, s1_eyy, s1_exy;
  logic [30:0]        s1_k, s1_g, s1_y, s1_th;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_exx <= s_axis_tdata[43:12];
      s1_eyy <= s_axis_tdata[75:44];
      s1_exy <= s_axis_tdata[107:76];
      s1_k   <= s_axis_tdata[138:108];
      s1_g   <= s_axis_tdata[169:139];
      s1_y   <= s_axis_tdata[200:170];
      s1_th  <= s_axis_tdata[231:201];
    end
  end

  // Elastic products and coefficient products
  logic signed [32:0] kpg, kmg, ediff;
  logic signed [64:0] pa, pb, pc, pd;
  logic signed [63:0] pe;
  logic [61:0]        qdg, rprod;
  logic [32:0]        incd;
  logic [31:0]        incxy;

  assign kpg   = $signed({1'b0, 32'(s1_k) + 32'(s1_g)});
  assign kmg   = $signed({2'b0, s1_k}) - $signed({2'b0, s1_g});
  assign pa    = 65'(kpg) * 65'(s1_exx);
  assign pb    = 65'(kmg) * 65'(s1_eyy);
  assign pc    = 65'(kmg) * 65'(s1_exx);
  assign pd    = 65'(kpg) * 65'(s1_eyy);
  assign pe    = 64'($signed({1'b0, s1_g})) * 64'(s1_exy);
  assign qdg   = 62'(time_step) * 62'(s1_g);
  assign rprod = 62'(time_step) * 62'(inv_visc);
  assign ediff = 33'(s1_exx) - 33'(s1_eyy);
  assign incd  = ediff[32] ? 33'(-ediff) : 33'(ediff);
  assign incxy = s1_exy[31] ? 32'(-s1_exy) : 32'(s1_exy);

  // Stage 2
  logic signed [64:0] s2_pa, s2_pb, s2_pc, s2_pd;
  logic signed [63:0] s2_pe;
  logic [61:0]        s2_qdg, s2_rprod;
  logic [32:0]        s2_incd;
  logic [31:0]        s2_incxy;
  logic [30:0]        s2_y, s2_th;
  vsu_pkg::pt_state_t s2_st;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pa    <= pa;
      s2_pb    <= pb;
      s2_pc    <= pc;
      s2_pd    <= pd;
      s2_pe    <= pe;
      s2_qdg   <= qdg;
      s2_rprod <= rprod;
      s2_incd  <= incd;
      s2_incxy <= incxy;
      s2_y     <= s1_y;
      s2_th    <= s1_th;
      s2_st    <= st_rd;
    end
  end

  // Trial stress, coefficients, stored deviators
  logic signed [31:0] txx, tyy, txy;
  logic [30:0]        c1, rr;
  logic signed [32:0] sm;
  logic signed [33:0] vxx, vyy;

  assign txx = vsu_pkg::sat32(68'(s2_pa >>> FRAC_BITS) + 68'(s2_pb >>> FRAC_BITS)
                              + 68'(s2_st.sxx));
  assign tyy = vsu_pkg::sat32(68'(s2_pc >>> FRAC_BITS) + 68'(s2_pd >>> FRAC_BITS)
                              + 68'(s2_st.syy));
  assign txy = vsu_pkg::sat32(68'(s2_pe >>> FRAC_BITS) + 68'(s2_st.sxy));
  assign c1  = vsu_pkg::sat31u(64'(s2_qdg >> FRAC_BITS));
  assign rr  = vsu_pkg::sat31u(64'(s2_rprod >> FRAC_BITS));
  assign sm  = (33'(s2_st.sxx) + 33'(s2_st.syy)) >>> 1;
  assign vxx = 34'(s2_st.sxx) - 34'(sm);
  assign vyy = 34'(s2_st.syy) - 34'(sm);

  // Stage 3
  logic signed [31:0] s3_txx, s3_tyy, s3_txy, s3_vxy;
  logic [30:0]        s3_c1, s3_r, s3_y, s3_th;
  logic signed [33:0] s3_vxx, s3_vyy;
  logic [32:0]        s3_incd;
  logic [31:0]        s3_incxy;
  vsu_pkg::pt_state_t s3_st;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_txx   <= txx;
      s3_tyy   <= tyy;
      s3_txy   <= txy;
      s3_c1    <= c1;
      s3_r     <= rr;
      s3_vxx   <= vxx;
      s3_vyy   <= vyy;
      s3_vxy   <= s2_st.sxy;
      s3_incd  <= s2_incd;
      s3_incxy <= s2_incxy;
      s3_y     <= s2_y;
      s3_th    <= s2_th;
      s3_st    <= s2_st;
    end
  end

  // Trial mean and deviators, relaxation product, plastic rate products
  logic signed [32:0] tm;
  logic signed [33:0] dxx, dyy;
  logic [61:0]        cprod;
  logic [33:0]        avxx, avyy;
  logic [31:0]        avxy;
  logic [63:0]        ppxx, ppyy, ppxy;

  assign tm    = (33'(s3_txx) + 33'(s3_tyy)) >>> 1;
  assign dxx   = 34'(s3_txx) - 34'(tm);
  assign dyy   = 34'(s3_tyy) - 34'(tm);
  assign cprod = 62'(s3_c1) * 62'(inv_visc);
  assign avxx  = s3_vxx[33] ? 34'(-s3_vxx) : 34'(s3_vxx);
  assign avyy  = s3_vyy[33] ? 34'(-s3_vyy) : 34'(s3_vyy);
  assign avxy  = s3_vxy[31] ? 32'(-s3_vxy) : 32'(s3_vxy);
  assign ppxx  = 64'(avxx) * 64'(s3_r);
  assign ppyy  = 64'(avyy) * 64'(s3_r);
  assign ppxy  = 64'(avxy) * 64'(s3_r);

  // Stage 4
  logic signed [32:0] s4_tm;
  logic signed [33:0] s4_dxx, s4_dyy, s4_vxx, s4_vyy;
  logic signed [31:0] s4_txy, s4_vxy;
  logic [61:0]        s4_cprod;
  logic [63:0]        s4_ppxx, s4_ppyy, s4_ppxy;
  logic [32:0]        s4_incd;
  logic [31:0]        s4_incxy;
  logic [30:0]        s4_y, s4_th;
  vsu_pkg::pt_state_t s4_st;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tm    <= tm;
      s4_dxx   <= dxx;
      s4_dyy   <= dyy;
      s4_txy   <= s3_txy;
      s4_vxx   <= s3_vxx;
      s4_vyy   <= s3_vyy;
      s4_vxy   <= s3_vxy;
      s4_cprod <= cprod;
      s4_ppxx  <= ppxx;
      s4_ppyy  <= ppyy;
      s4_ppxy  <= ppxy;
      s4_incd  <= s3_incd;
      s4_incxy <= s3_incxy;
      s4_y     <= s3_y;
      s4_th    <= s3_th;
      s4_st    <= s3_st;
    end
  end

  // Relaxation coefficient and squares for the yield and redraw tests
  logic [30:0]        cc;
  logic signed [67:0] sqd_full, sqt_full;
  logic [61:0]        ysq, thsq;

  assign cc       = vsu_pkg::sat31u(64'(s4_cprod >> FRAC_BITS));
  assign sqd_full = 68'(s4_dxx) * 68'(s4_dxx);
  assign sqt_full = 68'(s4_txy) * 68'(s4_txy);
  assign ysq      = 62'(s4_y) * 62'(s4_y);
  assign thsq     = 62'(s4_th) * 62'(s4_th);

  // Stage 5
  logic [30:0]        s5_c;
  logic [63:0]        s5_sqd, s5_sqt;
  logic [61:0]        s5_ysq, s5_thsq;
  logic [63:0]        s5_ppxx, s5_ppyy, s5_ppxy;
  logic signed [32:0] s5_tm;
  logic signed [33:0] s5_dxx, s5_dyy, s5_vxx, s5_vyy;
  logic signed [31:0] s5_txy, s5_vxy;
  logic [32:0]        s5_incd;
  logic [31:0]        s5_incxy;
  vsu_pkg::pt_state_t s5_st;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_c     <= cc;
      s5_sqd   <= sqd_full[63:0];
      s5_sqt   <= sqt_full[63:0];
      s5_ysq   <= ysq;
      s5_thsq  <= thsq;
      s5_ppxx  <= s4_ppxx;
      s5_ppyy  <= s4_ppyy;
      s5_ppxy  <= s4_ppxy;
      s5_tm    <= s4_tm;
      s5_dxx   <= s4_dxx;
      s5_dyy   <= s4_dyy;
      s5_vxx   <= s4_vxx;
      s5_vyy   <= s4_vyy;
      s5_txy   <= s4_txy;
      s5_vxy   <= s4_vxy;
      s5_incd  <= s4_incd;
      s5_incxy <= s4_incxy;
      s5_st    <= s4_st;
    end
  end

  // Yield decision, relaxation products, accumulator updates
  logic [64:0]        j2;
  logic               pl;
  logic signed [65:0] mvxx, mvyy, mvxy;
  logic [31:0]        npxx, npyy, npxy, naxx, nayy, naxy;

  assign j2 = 65'(s5_sqd) + 65'(s5_sqt);
  assign pl = (j2 >= 65'(s5_ysq)) || s5_st.act || (s5_st.pxx != '0) || (s5_st.pxy != '0);

  assign mvxx = 66'(s5_vxx) * 66'($signed({1'b0, s5_c}));
  assign mvyy = 66'(s5_vyy) * 66'($signed({1'b0, s5_c}));
  assign mvxy = 66'(s5_vxy) * 66'($signed({1'b0, s5_c}));

  assign npxx = pl ? vsu_pkg::acc_sat(s5_st.pxx, s5_ppxx >> FRAC_BITS) : s5_st.pxx;
  assign npyy = pl ? vsu_pkg::acc_sat(s5_st.pyy, s5_ppyy >> FRAC_BITS) : s5_st.pyy;
  assign npxy = pl ? vsu_pkg::acc_sat(s5_st.pxy, s5_ppxy >> FRAC_BITS) : s5_st.pxy;
  assign naxx = pl ? vsu_pkg::acc_sat(s5_st.axx, 64'(s5_incd)) : s5_st.axx;
  assign nayy = pl ? vsu_pkg::acc_sat(s5_st.ayy, 64'(s5_incd)) : s5_st.ayy;
  assign naxy = pl ? vsu_pkg::acc_sat(s5_st.axy, 64'(s5_incxy)) : s5_st.axy;

  // Stage 6: drop the relaxation term for an elastic point
  logic               s6_pl;
  logic signed [65:0] s6_mvxx, s6_mvyy, s6_mvxy;
  logic signed [32:0] s6_tm;
  logic signed [33:0] s6_dxx, s6_dyy;
  logic signed [31:0] s6_txy;
  logic [61:0]        s6_thsq;
  logic [31:0]        s6_pxx, s6_pyy, s6_pxy, s6_axx, s6_ayy, s6_axy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_pl   <= pl;
      s6_mvxx <= pl ? mvxx : '0;
      s6_mvyy <= pl ? mvyy : '0;
      s6_mvxy <= pl ? mvxy : '0;
      s6_tm   <= s5_tm;
      s6_dxx  <= s5_dxx;
      s6_dyy  <= s5_dyy;
      s6_txy  <= s5_txy;
      s6_thsq <= s5_thsq;
      s6_pxx  <= npxx;
      s6_pyy  <= npyy;
      s6_pxy  <= npxy;
      s6_axx  <= naxx;
      s6_ayy  <= nayy;
      s6_axy  <= naxy;
    end
  end

  // Updated stress and accumulated strain squares
  logic signed [31:0] oxx, oyy, oxy;
  logic [61:0]        a0sq, a2sq;

  assign oxx  = vsu_pkg::sat32(68'(s6_dxx) - 68'(s6_mvxx >>> FRAC_BITS) + 68'(s6_tm));
  assign oyy  = vsu_pkg::sat32(68'(s6_dyy) - 68'(s6_mvyy >>> FRAC_BITS) + 68'(s6_tm));
  assign oxy  = vsu_pkg::sat32(68'(s6_txy) - 68'(s6_mvxy >>> FRAC_BITS));
  assign a0sq = 62'(s6_axx[30:0]) * 62'(s6_axx[30:0]);
  assign a2sq = 62'(s6_axy[30:0]) * 62'(s6_axy[30:0]);

  // Stage 7
  logic               s7_act;
  logic signed [31:0] s7_oxx, s7_oyy, s7_oxy;
  logic [61:0]        s7_a0sq, s7_a2sq, s7_thsq;
  logic [31:0]        s7_pxx, s7_pyy, s7_pxy, s7_axx, s7_ayy, s7_axy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_act  <= s6_pl;
      s7_oxx  <= oxx;
      s7_oyy  <= oyy;
      s7_oxy  <= oxy;
      s7_a0sq <= a0sq;
      s7_a2sq <= a2sq;
      s7_thsq <= s6_thsq;
      s7_pxx  <= s6_pxx;
      s7_pyy  <= s6_pyy;
      s7_pxy  <= s6_pxy;
      s7_axx  <= s6_axx;
      s7_ayy  <= s6_ayy;
      s7_axy  <= s6_axy;
    end
  end

  // Redraw test and write-back word
  logic [62:0] eff;
  logic        redraw;

  assign eff    = 63'(s7_a0sq) + 63'(s7_a2sq);
  assign redraw = s7_act && (eff >= 63'(s7_thsq));

  always_comb begin
    st_wr.sxx = s7_oxx;
    st_wr.syy = s7_oyy;
    st_wr.sxy = s7_oxy;
    st_wr.axx = redraw ? '0 : s7_axx;
    st_wr.ayy = redraw ? '0 : s7_ayy;
    st_wr.axy = redraw ? '0 : s7_axy;
    st_wr.pxx = redraw ? '0 : s7_pxx;
    st_wr.pyy = redraw ? '0 : s7_pyy;
    st_wr.pxy = redraw ? '0 : s7_pxy;
    st_wr.act = s7_act && !redraw;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {s7_oxy, s7_oyy, s7_oxx};
      m_axis_tuser <= {redraw, s7_act && !redraw};
    end
  end

`ifndef SYNTH
  // A point never occupies stage 1 and stage 2 at once
  a_no_dup_point: assert property (@(posedge clk) disable iff (rst)
    vld[1] && vld[2] |-> pt[1] != pt[2])
    else $error("same point in two adjacent stages");

  // A redrawn point leaves the plastic state
  a_redraw_clears: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("redraw reported with plastic_active set");

  // A stalled output freezes the pipeline
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld))
    else $error("pipeline moved during output stall");

  // The clearing pass runs once after reset
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !clr_busy |=> !clr_busy)
    else $error("clearing pass restarted");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for viscoplastic_stress_update: streams quadrature points,
// predicts each stress result in a scoreboard class and compares every output transfer.
// Depends on vsu_pkg and the RTL of viscoplastic_stress_update.
`timescale 1ns / 100ps

typedef struct {
  logic [11:0]        idx;
  logic signed [31:0] exx;
  logic signed [31:0] eyy;
  logic signed [31:0] exy;
  logic [30:0]        k;
  logic [30:0]        g;
  logic [30:0]        y;
  logic [30:0]        th;
} point_in_t;

typedef struct {
  logic [31:0] sxx;
  logic [31:0] syy;
  logic [31:0] sxy;
  logic        act;
  logic        redraw;
} stress_out_t;

class stress_scoreboard;
  localparam longint MAXV = 64'd2147483647;
  localparam int FRAC = 16;

  longint sxx_m[4096];
  longint syy_m[4096];
  longint sxy_m[4096];
  longint axx_m[4096];
  longint ayy_m[4096];
  longint axy_m[4096];
  longint pxx_m[4096];
  longint pyy_m[4096];
  longint pxy_m[4096];
  bit     act_m[4096];
  longint dt;
  longint inv_visc;
  stress_out_t pending[$];
  int errors;

  function new();
    dt = 65536;
    inv_visc = 65536;
    errors = 0;
  endfunction

  // Q.F product, rounded toward minus infinity
  static function longint mulq(longint a, longint b);
    logic signed [127:0] p;
    p = a;
    p = p * b;
    return longint'(p >>> FRAC);
  endfunction

  static function longint mulu_sat31(longint a, longint b);
    longint p;
    p = (a * b) >>> FRAC;
    return (p > MAXV) ? MAXV : p;
  endfunction

  static function longint clamp32(longint v);
    if (v > MAXV) return MAXV;
    if (v < -MAXV - 1) return -MAXV - 1;
    return v;
  endfunction

  static function longint acc_add(longint a, longint inc);
    longint s;
    s = a + inc;
    return (s > MAXV) ? MAXV : s;
  endfunction

  static function longint absv(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Update the point state and queue the stress it must produce
  function void note_point(point_in_t it);
    int i;
    longint exx, eyy, exy, k, g, y, th, sxx, syy, sxy;
    longint txx, tyy, txy, tm, dxx, dyy, sm, c, r, oxx, oyy, oxy, a0, a2;
    longint unsigned j2;
    bit act, redraw;
    stress_out_t o;
    i = int'(it.idx);
    exx = longint'(it.exx); eyy = longint'(it.eyy); exy = longint'(it.exy);
    k = longint'(it.k); g = longint'(it.g); y = longint'(it.y); th = longint'(it.th);
    sxx = sxx_m[i]; syy = syy_m[i]; sxy = sxy_m[i];
    act = act_m[i];
    redraw = 0;
    txx = clamp32(mulq(k + g, exx) + mulq(k - g, eyy) + sxx);
    tyy = clamp32(mulq(k - g, exx) + mulq(k + g, eyy) + syy);
    txy = clamp32(mulq(g, exy) + sxy);
    tm = (txx + tyy) >>> 1;
    dxx = txx - tm;
    dyy = tyy - tm;
    // The sum of squares can reach 2^63, so add it unsigned
    j2 = longint'(unsigned'(dxx * dxx)) + longint'(unsigned'(txy * txy));
    j2 = 64'(dxx * dxx) + 64'(txy * txy);
    if (j2 >= 64'(y * y) || act || pxx_m[i] != 0 || pxy_m[i] != 0) begin
      sm = (sxx + syy) >>> 1;
      c = mulu_sat31(mulu_sat31(dt, g), inv_visc);
      r = mulu_sat31(dt, inv_visc);
      act = 1;
      oxx = clamp32(dxx - mulq(sxx - sm, c) + tm);
      oyy = clamp32(dyy - mulq(syy - sm, c) + tm);
      oxy = clamp32(txy - mulq(sxy, c));
      pxx_m[i] = acc_add(pxx_m[i], mulq(absv(sxx - sm), r));
      pyy_m[i] = acc_add(pyy_m[i], mulq(absv(syy - sm), r));
      pxy_m[i] = acc_add(pxy_m[i], mulq(absv(sxy), r));
      axx_m[i] = acc_add(axx_m[i], absv(exx - eyy));
      ayy_m[i] = acc_add(ayy_m[i], absv(eyy - exx));
      axy_m[i] = acc_add(axy_m[i], absv(exy));
    end else begin
      oxx = txx; oyy = tyy; oxy = txy;
    end
    // Redraw clears the point once its accumulated strain reaches the threshold
    if (act) begin
      a0 = axx_m[i];
      a2 = axy_m[i];
      if (a0 * a0 + a2 * a2 >= th * th) begin
        pxx_m[i] = 0; pyy_m[i] = 0; pxy_m[i] = 0;
        axx_m[i] = 0; ayy_m[i] = 0; axy_m[i] = 0;
        act = 0;
        redraw = 1;
      end
    end
    sxx_m[i] = oxx; syy_m[i] = oyy; sxy_m[i] = oxy;
    act_m[i] = act;
    o.sxx = oxx[31:0]; o.syy = oyy[31:0]; o.sxy = oxy[31:0];
    o.act = act; o.redraw = redraw;
    pending.push_back(o);
  endfunction

  function void check_result(logic [95:0] d, logic [1:0] u);
    stress_out_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: tdata=%h tuser=%b", d, u);
      return;
    end
    e = pending.pop_front();
    if (d !== {e.sxy, e.syy, e.sxx} || u !== {e.redraw, e.act}) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: sxx %h/%h syy %h/%h sxy %h/%h act %b/%b redraw %b/%b (exp/got)",
                 e.sxx, d[31:0], e.syy, d[63:32], e.sxy, d[95:64],
                 e.act, u[0], e.redraw, u[1]);
    end
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT = 400000;

  logic                       clk = 0;
  logic                       rst = 1;
  logic                       s_axis_tvalid = 0;
  logic                       s_axis_tready;
  logic [vsu_pkg::IN_W-1:0]   s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 0;
  logic [vsu_pkg::OUT_W-1:0]  m_axis_tdata;
  logic [vsu_pkg::USER_W-1:0] m_axis_tuser;
  logic                       cfg_wen = 0;
  vsu_pkg::cfg_reg_t          cfg_addr = vsu_pkg::REG_TIME_STEP;
  logic [vsu_pkg::CFG_W-1:0]  cfg_wdata = '0;

  stress_scoreboard stress_sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  recv_hold = 0;
  int  cycles = 0;

  viscoplastic_stress_update i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver readiness: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) stress_sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL viscoplastic_stress_update");
      $finish;
    end
  end

  // Drive one point, with random idle cycles ahead of it
  task automatic send_point(point_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.th, it.y, it.g, it.k, it.exy, it.eyy, it.exx, it.idx};
    do @(posedge clk); while (!s_axis_tready);
    stress_sb.note_point(it);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (stress_sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic write_regs(logic [30:0] dt, logic [30:0] iv);
    drain();
    cfg_wen <= 1'b1; cfg_addr <= vsu_pkg::REG_TIME_STEP; cfg_wdata <= dt;
    @(negedge clk);
    cfg_addr <= vsu_pkg::REG_INV_VISC; cfg_wdata <= iv;
    @(negedge clk);
    cfg_wen <= 1'b0;
    stress_sb.dt = longint'(dt);
    stress_sb.inv_visc = longint'(iv);
  endtask

  function automatic point_in_t mk(int idx, int exx, int eyy, int exy,
                                   int k, int g, int y, int th);
    point_in_t it;
    it.idx = 12'(idx); it.exx = exx; it.eyy = eyy; it.exy = exy;
    it.k = 31'(k); it.g = 31'(g); it.y = 31'(y); it.th = 31'(th);
    return it;
  endfunction

  // Mostly realistic points on a few indexes so they yield and redraw; rest is noise
  function automatic point_in_t rand_point();
    point_in_t it;
    if ($urandom_range(99) < 75) begin
      it.idx = 12'($urandom_range(15) + ($urandom_range(3) << 10));
      it.exx = int'($urandom_range(262144)) - 131072;
      it.eyy = int'($urandom_range(262144)) - 131072;
      it.exy = int'($urandom_range(262144)) - 131072;
      it.k = 31'($urandom_range(1 << 20));
      it.g = 31'($urandom_range(1 << 20));
      it.y = 31'($urandom_range(1 << 21));
      it.th = 31'($urandom_range(1 << 19));
    end else begin
      it.idx = 12'($urandom); it.exx = $urandom; it.eyy = $urandom; it.exy = $urandom;
      it.k = 31'($urandom); it.g = 31'($urandom); it.y = 31'($urandom);
      it.th = 31'($urandom);
    end
    return it;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_point(rand_point());
  endtask

  localparam int MX = 32'h7fffffff;
  localparam int MN = 32'h80000000;
  localparam int ONE = 65536;

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed points
    write_regs(31'd65536, 31'd65536);
    send_point(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_point(mk(4095, MX, MN, MX, MX, MX, MX, MX));
    send_point(mk(4095, MN, MX, MN, MX, MX, MX, MX));
    send_point(mk(4095, MX, MX, MN, MX, 0, MX, MX));
    send_point(mk(1, ONE, -ONE, ONE, 4 * ONE, 2 * ONE, MX, MX));
    send_point(mk(1, ONE, ONE, 0, 4 * ONE, 2 * ONE, 0, MX));
    send_point(mk(1, -ONE, ONE, ONE, 4 * ONE, 2 * ONE, MX, MX));
    send_point(mk(1, ONE, 0, 0, 4 * ONE, 2 * ONE, MX, 0));
    repeat (5) send_point(mk(2, ONE, -ONE, ONE / 2, ONE, ONE, 0, 5 * ONE));
    repeat (3) send_point(mk(3, MX, MN, MX, 0, ONE, 0, MX));
    send_point(mk(5, MN, MN, MN, 0, MX, MX, MX));
    send_point(mk(6, 0, 0, 0, MX, 0, 0, MX));
    send_point(mk(6, 3, -7, 5, 1, 1, 1, 1));

    // Phase 1: sender idles more rarely than the receiver
    send_idle_pct = 22; recv_idle_pct = 56;
    write_regs(31'd0, 31'h7fffffff);
    random_phase(420);

    // Phase 2: roles swapped, extreme registers
    send_idle_pct = 56; recv_idle_pct = 22;
    write_regs(31'h7fffffff, 31'h7fffffff);
    random_phase(420);

    // Phase 3: no idling; receiver holds off so the pipeline backs up
    send_idle_pct = 0; recv_idle_pct = 0;
    write_regs(31'($urandom_range(1 << 18)), 31'($urandom_range(1 << 18)));
    recv_hold = 300;
    random_phase(420);

    drain();
    repeat (20) @(posedge clk);
    if (stress_sb.errors == 0 && stress_sb.pending.size() == 0) begin
      $display("PASS viscoplastic_stress_update");
    end else begin
      $display("FAIL viscoplastic_stress_update");
    end
    $finish;
  end
endmodule
